### sv/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
// Field widths, status and register codes, defaults and sequencer states.
// No dependencies.
`default_nettype none

package fbpa_pkg;

  localparam int OFF_W    = 20;
  localparam int STATUS_W = 3;
  localparam int FREE_W   = 9;
  localparam int BSIZE_W  = 13;
  localparam int BCOUNT_W = 9;
  localparam int CFG_W    = 32;
  localparam int ADDR_W   = 3;

  localparam int DEF_MAX_BLOCKS     = 256;
  localparam int DEF_MAX_BLOCK_SIZE = 4096;

  localparam logic [BSIZE_W-1:0]  RST_BLOCK_SIZE  = BSIZE_W'(64);
  localparam logic [BCOUNT_W-1:0] RST_BLOCK_COUNT = BCOUNT_W'(256);

  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISALIGNED = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC  = 3'd4;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_INIT,
    SQ_A_LINK,
    SQ_MUL,
    SQ_DIV,
    SQ_R_LINK,
    SQ_RESULT
  } sq_state_t;

endpackage

`default_nettype wire

### sv/fbpa_div.sv
// Restoring divider, one quotient bit per cycle, for offset to block index.
// Depends on fbpa_pkg for the offset width.
`default_nettype none

module fbpa_div
  import fbpa_pkg::*;
#(
  parameter int DW = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [OFF_W-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [OFF_W-1:0] quotient,
  output logic [DW-1:0]    remainder
);

  localparam int CNT_W = $clog2(OFF_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [OFF_W-1:0] quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW:0]      sh;
  logic [DW:0]      diff;
  logic             ge;

  assign sh   = {rem_r, quo_r[OFF_W-1]};
  assign diff = sh - {1'b0, divisor};
  assign ge   = (sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1)) && !start;
      if (start) begin
        cnt_r <= CNT_W'(OFF_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[OFF_W-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : sh[DW-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### sv/fbpa_link_ram.sv
// Link table memory: one write port, one registered read port.
// Depends on fbpa_pkg for the default depth.
`default_nettype none

module fbpa_link_ram
  import fbpa_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_BLOCKS,
  parameter int W     = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/fixed_block_pool_allocator_unit.sv
// Fixed block pool allocator: free list in a link RAM, iterative divider for release.
// Allocate: states A_LINK (released head only), MUL, RESULT; an empty pool goes to RESULT.
// Release: DIV (20-step divider), then R_LINK when the link entry is read, then RESULT.
// Next transaction is accepted in the same cycle that the result turns valid; output stalls hold it.
// Reset and any register write rebuild the list in the INIT state; a fill count tracks untouched RAM.
// Depends on fbpa_pkg, fbpa_div, fbpa_link_ram.
`default_nettype none

module fixed_block_pool_allocator_unit
  import fbpa_pkg::*;
#(
  parameter int MAX_BLOCKS     = DEF_MAX_BLOCKS,
  parameter int MAX_BLOCK_SIZE = DEF_MAX_BLOCK_SIZE
) (
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: release_offset[19:0], zero pad [23:20]
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,
  // in_tuser: mode[0]
  input  logic              in_tuser,
  // out_tdata: block_offset[19:0], free_count[28:20], zero pad [31:29]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  // out_tuser: status[2:0]
  output logic [STATUS_W-1:0] out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_W-1:0]  cfg_pwdata,
  output logic [CFG_W-1:0]  cfg_prdata,
  output logic              cfg_pready
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = $clog2(MAX_BLOCK_SIZE + 1);
  localparam int PW = IW + SW;
  localparam logic [LW-1:0] LINK_NULL = LW'(MAX_BLOCKS);

  sq_state_t state_r, state_nxt;

  logic [BSIZE_W-1:0]  block_size_r;
  logic [BCOUNT_W-1:0] block_count_r;
  logic [LW-1:0]       head_r;
  logic [LW-1:0]       fill_r;
  logic [LW-1:0]       free_r;
  logic                out_valid_r;

  logic [IW-1:0]       idx_r;
  logic [STATUS_W-1:0] status_r;
  logic [OFF_W-1:0]    res_off_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [OFF_W-1:0]    out_off_r;
  logic [FREE_W-1:0]   out_free_r;

  logic              cfg_wr;
  logic              in_acc;
  logic              in_mode;
  logic [SW-1:0]     size_eff;
  logic [LW-1:0]     cnt_eff;
  logic              head_null;
  logic              head_fresh;
  logic [LW-1:0]     fresh_next;
  logic [PW-1:0]     prod;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [LW:0]       mem_wdata;
  logic [IW-1:0]     mem_raddr;
  logic [LW:0]       mem_rdata;
  logic              rd_alloc;
  logic [LW-1:0]     rd_link;

  logic              div_start;
  logic              div_done;
  logic [OFF_W-1:0]  div_quo;
  logic [SW-1:0]     div_rem;
  logic              rel_misaligned;
  logic              rel_range;
  logic              rel_fresh;
  logic              out_load;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_BLOCK_SIZE) ? CFG_W'(block_size_r)
                                                       : CFG_W'(block_count_r);

  assign in_tready = (state_r == SQ_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign in_mode   = in_tuser;

  always_comb begin
    if (block_size_r == '0) begin
      size_eff = SW'(1);
    end else if (32'(block_size_r) > 32'(MAX_BLOCK_SIZE)) begin
      size_eff = SW'(MAX_BLOCK_SIZE);
    end else begin
      size_eff = SW'(block_size_r);
    end
  end

  assign cnt_eff = (32'(block_count_r) > 32'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS)
                                                          : LW'(block_count_r);

  assign head_null  = (head_r == LINK_NULL);
  assign head_fresh = (head_r == fill_r);
  assign fresh_next = (({1'b0, head_r} + (LW+1)'(1)) < {1'b0, cnt_eff}) ?
                      (head_r + LW'(1)) : LINK_NULL;

  assign rd_alloc = mem_rdata[LW];
  assign rd_link  = mem_rdata[LW-1:0];

  assign rel_misaligned = (div_rem != '0);
  assign rel_range      = (32'(div_quo) >= 32'(cnt_eff));
  assign rel_fresh      = (32'(div_quo) >= 32'(fill_r));

  assign prod = PW'(idx_r) * PW'(size_eff);

  fbpa_div #(
    .DW(SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_tdata[OFF_W-1:0]),
    .divisor  (size_eff),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  fbpa_link_ram #(
    .DEPTH(MAX_BLOCKS),
    .W    (LW + 1)
  ) u_link_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    priority if (cfg_wr) begin
      state_nxt = SQ_INIT;
    end else begin
      unique case (state_r)
        SQ_IDLE: begin
          if (in_acc) begin
            priority if (in_mode == MODE_RELEASE) begin
              state_nxt = SQ_DIV;
            end else if (head_null) begin
              state_nxt = SQ_RESULT;
            end else if (head_fresh) begin
              state_nxt = SQ_MUL;
            end else begin
              state_nxt = SQ_A_LINK;
            end
          end
        end
        SQ_INIT:   state_nxt = SQ_IDLE;
        SQ_A_LINK: state_nxt = SQ_MUL;
        SQ_MUL:    state_nxt = SQ_RESULT;
        SQ_DIV: begin
          if (div_done) begin
            state_nxt = (rel_misaligned || rel_range || rel_fresh) ? SQ_RESULT : SQ_R_LINK;
          end
        end
        SQ_R_LINK: state_nxt = SQ_RESULT;
        SQ_RESULT: begin
          if (!out_valid_r || out_tready) begin
            state_nxt = SQ_IDLE;
          end
        end
        default:   state_nxt = SQ_IDLE;
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = {1'b1, LINK_NULL};
    mem_raddr = (state_r == SQ_IDLE) ? head_r[IW-1:0] : div_quo[IW-1:0];
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      SQ_IDLE: begin
        div_start = in_acc && (in_mode == MODE_RELEASE);
        if (in_acc && (in_mode == MODE_ALLOC) && !head_null && head_fresh) begin
          mem_we    = 1'b1;
          mem_waddr = head_r[IW-1:0];
        end
      end
      SQ_A_LINK: mem_we = 1'b1;
      SQ_R_LINK: begin
        mem_we    = rd_alloc;
        mem_wdata = {1'b0, head_r};
      end
      SQ_RESULT: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= SQ_INIT;
      block_size_r  <= RST_BLOCK_SIZE;
      block_count_r <= RST_BLOCK_COUNT;
      head_r        <= LINK_NULL;
      fill_r        <= '0;
      free_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_BLOCK_SIZE) begin
          block_size_r <= cfg_pwdata[BSIZE_W-1:0];
        end else begin
          block_count_r <= cfg_pwdata[BCOUNT_W-1:0];
        end
      end
      unique case (state_r)
        SQ_INIT: begin
          fill_r <= '0;
          head_r <= (cnt_eff != '0) ? '0 : LINK_NULL;
          free_r <= cnt_eff;
        end
        SQ_IDLE: begin
          if (in_acc && (in_mode == MODE_ALLOC) && !head_null && head_fresh) begin
            head_r <= fresh_next;
            fill_r <= fill_r + LW'(1);
            if (free_r != '0) free_r <= free_r - LW'(1);
          end
        end
        SQ_A_LINK: begin
          head_r <= rd_link;
          if (free_r != '0) free_r <= free_r - LW'(1);
        end
        SQ_R_LINK: begin
          if (rd_alloc) begin
            head_r <= LW'(idx_r);
            free_r <= free_r + LW'(1);
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      SQ_IDLE: begin
        if (in_acc) begin
          res_off_r <= '0;
          idx_r     <= head_r[IW-1:0];
          status_r  <= (in_mode == MODE_ALLOC && head_null) ? STATUS_EMPTY : STATUS_OK;
        end
      end
      SQ_MUL: res_off_r <= OFF_W'(prod);
      SQ_DIV: begin
        if (div_done) begin
          idx_r <= div_quo[IW-1:0];
          priority if (rel_misaligned) begin
            status_r <= STATUS_MISALIGNED;
          end else if (rel_range) begin
            status_r <= STATUS_RANGE;
          end else if (rel_fresh) begin
            status_r <= STATUS_NOT_ALLOC;
          end else begin
            status_r <= STATUS_OK;
          end
        end
      end
      SQ_R_LINK: begin
        if (!rd_alloc) status_r <= STATUS_NOT_ALLOC;
      end
      default: ;
    endcase
    if (out_load) begin
      out_status_r <= status_r;
      out_off_r    <= res_off_r;
      out_free_r   <= FREE_W'(free_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_free_r, out_off_r};

  a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != SQ_INIT) |-> (free_r <= cnt_eff && fill_r <= cnt_eff))
    else $error("free or fill count exceeds pool size");

  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_IDLE) |-> (head_null == (free_r == '0)))
    else $error("free list head and free count disagree");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == SQ_DIV))
    else $error("divider finished outside release sequence");

  a_no_write_on_fresh_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_R_LINK) |-> (32'(idx_r) < 32'(fill_r)))
    else $error("release reads an untouched link entry");

endmodule

`default_nettype wire
